// ===== sv/aes128_xts_sector_crypt_defines.svh =====
// assertion helpers shared by the rtl
`ifndef AES128_XTS_SECTOR_CRYPT_DEFINES_SVH
`define AES128_XTS_SECTOR_CRYPT_DEFINES_SVH

// condition now implies consequence in the same cycle
`define AXSC_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// condition now implies consequence in the next cycle
`define AXSC_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== sv/axsc_pkg.sv =====
package axsc_pkg;

    typedef enum logic [2:0] {
        REG_KEY1_LOW     = 3'd0,
        REG_KEY1_HIGH    = 3'd1,
        REG_KEY2_LOW     = 3'd2,
        REG_KEY2_HIGH    = 3'd3,
        REG_START_SECTOR = 3'd4,
        REG_ENCRYPT_MODE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic en;
        logic enc;
        logic final_round;
    } round_ctl_t;

    // cycles for the key schedule chain to refill after a key write
    localparam logic [3:0] SETTLE_CYCLES = 4'd10;

    localparam logic [127:0] GF_POLY = 128'h87;

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // multiply by a small constant in GF(2^8)
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                r = r ^ p;
            end
            p = xt(p);
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[7:0];
        a1 = c[15:8];
        a2 = c[23:16];
        a3 = c[31:24];
        return {xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3),
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[7:0];
        a1 = c[15:8];
        a2 = c[23:16];
        a3 = c[31:24];
        return {gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9) ^ gm(a3, 4'd14),
                gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14) ^ gm(a3, 4'd11),
                gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11) ^ gm(a3, 4'd13),
                gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13) ^ gm(a3, 4'd9)};
    endfunction

endpackage

// ===== sv/axsc_key_cell.sv =====
module axsc_key_cell
    import axsc_pkg::*;
(
    input  logic         clk,
    input  logic [7:0]   rcon,
    input  logic [127:0] kin,
    output logic [127:0] kout
);

    logic [127:0] key_reg;
    logic [127:0] key_next;

    always_comb
    begin
        logic [31:0] t;
        t = {SBOX[kin[103:96]], SBOX[kin[127:120]], SBOX[kin[119:112]],
             SBOX[kin[111:104]] ^ rcon};
        key_next[31:0]   = kin[31:0] ^ t;
        key_next[63:32]  = kin[63:32] ^ key_next[31:0];
        key_next[95:64]  = kin[95:64] ^ key_next[63:32];
        key_next[127:96] = kin[127:96] ^ key_next[95:64];
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign kout = key_reg;

endmodule

// ===== sv/axsc_round_cell.sv =====
module axsc_round_cell
    import axsc_pkg::*;
(
    input  logic         clk,
    input  round_ctl_t   ctl,
    input  logic [127:0] rk,
    input  logic [127:0] din,
    output logic [127:0] dout
);

    logic [127:0] state_reg;
    logic [127:0] state_next;

    always_comb
    begin
        logic [127:0] t;
        logic [127:0] u;
        t = '0;
        u = '0;
        if (ctl.enc)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[8*(i+4*c) +: 8] = SBOX[din[8*(i+4*((c+i)%4)) +: 8]];
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                u[32*c +: 32] = ctl.final_round ? t[32*c +: 32] : mix_col(t[32*c +: 32]);
            end
            state_next = u ^ rk;
        end
        else
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[8*(i+4*((c+i)%4)) +: 8] = INV_SBOX[din[8*(i+4*c) +: 8]];
                end
            end
            t = t ^ rk;
            for (int c = 0; c < 4; c++)
            begin
                u[32*c +: 32] = ctl.final_round ? t[32*c +: 32]
                                                : inv_mix_col(t[32*c +: 32]);
            end
            state_next = u;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

// ===== sv/aes128_xts_sector_crypt.sv =====
// channel  | direction | handshake              | payload
// in       | input     | in_valid / in_ready    | data_low, data_high, last_block
// out      | output    | out_valid / out_ready  | result_low, result_high, last
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle while in_ready is high; pipeline: seed cipher row (11 stages), tweak
// merge stage, data cipher row (10 round cells), output register
// every stage moves on its own when the one after it is free or empty
// reset and every cfg write (not only key writes) hold in_ready low while the round key chain refills
// cfg_ready is always high; the tweak chain advances at the merge stage in item order
`include "aes128_xts_sector_crypt_defines.svh"

module aes128_xts_sector_crypt
    import axsc_pkg::*;
#(
    parameter int BLOCKS_PER_SECTOR = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_low,
    input  logic [63:0] data_high,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int BW = (BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1;
    localparam int NS = 23;
    localparam int MS = 11;

    logic [63:0]  key1_low_reg, key1_high_reg, key2_low_reg, key2_high_reg;
    logic [63:0]  start_sector_reg;
    logic         encrypt_mode_reg;
    logic [3:0]   settle_reg;
    logic [3:0]   settle_next;
    logic         cfg_we;

    logic [63:0]  cur_reg, cur_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic         run_start_reg, run_start_next;
    logic [127:0] twk_reg;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;
    logic          in_acc;

    logic [127:0] k1 [0:10];
    logic [127:0] k2 [0:10];
    logic [127:0] tst [0:10];
    logic [127:0] dst [0:10];
    logic [127:0] tst0_reg;
    logic [127:0] dst0_reg;
    logic [127:0] sd_data [0:10];
    logic         sd_last [0:10];
    logic         sd_first [0:10];
    logic [127:0] dtw [0:10];
    logic         dl [0:10];
    logic [127:0] out_reg;
    logic         out_last_reg;

    logic [63:0]  sec;
    logic [BW-1:0] blk;
    logic [127:0] seed;
    logic [127:0] tw_cur;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key1_low_reg     <= '0;
            key1_high_reg    <= '0;
            key2_low_reg     <= '0;
            key2_high_reg    <= '0;
            start_sector_reg <= '0;
            encrypt_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY1_LOW:     key1_low_reg     <= cfg_data;
                REG_KEY1_HIGH:    key1_high_reg    <= cfg_data;
                REG_KEY2_LOW:     key2_low_reg     <= cfg_data;
                REG_KEY2_HIGH:    key2_high_reg    <= cfg_data;
                REG_START_SECTOR: start_sector_reg <= cfg_data;
                REG_ENCRYPT_MODE: encrypt_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // key schedules, one round key per cell
    assign k1[0] = {key1_high_reg, key1_low_reg};
    assign k2[0] = {key2_high_reg, key2_low_reg};

    for (genvar j = 1; j <= 10; j++)
    begin : g_keys
        axsc_key_cell u_k1 (.clk(clk), .rcon(RCON[j-1]), .kin(k1[j-1]), .kout(k1[j]));
        axsc_key_cell u_k2 (.clk(clk), .rcon(RCON[j-1]), .kin(k2[j-1]), .kout(k2[j]));
    end

    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_we)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != 4'd0)
        begin
            settle_next = settle_reg - 4'd1;
        end
    end

    // stall chain: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0] && (settle_reg == 4'd0);
    assign in_acc   = in_valid && in_ready;

    // sector bookkeeping at acceptance
    always_comb
    begin
        sec = run_start_reg ? start_sector_reg : cur_reg;
        blk = run_start_reg ? '0 : blk_reg;
        if (blk == BW'(BLOCKS_PER_SECTOR - 1))
        begin
            blk_next = '0;
            cur_next = sec + 64'd1;
        end
        else
        begin
            blk_next = blk + BW'(1);
            cur_next = sec;
        end
        run_start_next = 1'b0;
        if (last_block)
        begin
            blk_next       = '0;
            cur_next       = start_sector_reg;
            run_start_next = 1'b1;
        end
        for (int b = 0; b < 8; b++)
        begin
            seed[64 + 8*b +: 8] = sec[8*(7-b) +: 8];
        end
        seed[63:0] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg    <= SETTLE_CYCLES;
            cur_reg       <= '0;
            blk_reg       <= '0;
            run_start_reg <= 1'b1;
            vld_reg       <= '0;
        end
        else
        begin
            settle_reg <= settle_next;
            if (in_acc)
            begin
                cur_reg       <= cur_next;
                blk_reg       <= blk_next;
                run_start_reg <= run_start_next;
            end
            if (adv[0])
            begin
                vld_reg[0] <= in_acc;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // seed cipher row
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            tst0_reg    <= seed ^ k2[0];
            sd_data[0]  <= {data_high, data_low};
            sd_last[0]  <= last_block;
            sd_first[0] <= (blk == '0);
        end
        for (int i = 1; i <= 10; i++)
        begin
            if (adv[i])
            begin
                sd_data[i]  <= sd_data[i-1];
                sd_last[i]  <= sd_last[i-1];
                sd_first[i] <= sd_first[i-1];
            end
        end
    end

    assign tst[0] = tst0_reg;

    for (genvar j = 1; j <= 10; j++)
    begin : g_tweak
        round_ctl_t tctl;
        assign tctl = '{en: adv[j], enc: 1'b1, final_round: (j == 10)};
        axsc_round_cell u_cell (.clk(clk), .ctl(tctl), .rk(k2[j]), .din(tst[j-1]),
                                .dout(tst[j]));
    end

    // tweak merge: fresh tweak at a sector start, else the doubled one
    assign tw_cur = sd_first[10] ? tst[10] : twk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twk_reg <= '0;
        end
        else if (adv[MS] && vld_reg[MS-1])
        begin
            twk_reg <= {tw_cur[126:0], 1'b0} ^ (tw_cur[127] ? GF_POLY : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[MS])
        begin
            dst0_reg <= sd_data[10] ^ tw_cur ^ (encrypt_mode_reg ? k1[0] : k1[10]);
            dtw[0]   <= tw_cur;
            dl[0]    <= sd_last[10];
        end
        for (int i = 1; i <= 10; i++)
        begin
            if (adv[MS+i])
            begin
                dtw[i] <= dtw[i-1];
                dl[i]  <= dl[i-1];
            end
        end
        if (adv[NS-1])
        begin
            out_reg      <= dst[10] ^ dtw[10];
            out_last_reg <= dl[10];
        end
    end

    assign dst[0] = dst0_reg;

    // data cipher row
    for (genvar j = 1; j <= 10; j++)
    begin : g_data
        round_ctl_t dctl;
        assign dctl = '{en: adv[MS+j], enc: encrypt_mode_reg, final_round: (j == 10)};
        axsc_round_cell u_cell (.clk(clk), .ctl(dctl),
                                .rk(encrypt_mode_reg ? k1[j] : k1[10-j]),
                                .din(dst[j-1]), .dout(dst[j]));
    end

    assign out_valid   = vld_reg[NS-1];
    assign result_low  = out_reg[63:0];
    assign result_high = out_reg[127:64];
    assign last        = out_last_reg;

    `AXSC_ASSERT_NOW(a_ready_settled, clk, rst_n, in_ready, settle_reg == 4'd0, "input taken while keys settle")
    `AXSC_ASSERT_NEXT(a_cfg_blocks_in, clk, rst_n, cfg_we, !in_ready, "input open right after a key write")
    `AXSC_ASSERT_NEXT(a_last_restarts, clk, rst_n, in_acc && last_block, run_start_reg && blk_reg == '0, "run not restarted after last item")
    `AXSC_ASSERT_NEXT(a_tweak_chain, clk, rst_n, adv[MS] && vld_reg[MS-1] && !sd_first[10], dtw[0] == $past(twk_reg), "chained tweak not used")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import axsc_pkg::*;
();

    localparam int SECTOR_BLOCKS = 32;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        lst;
    } block_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        last_block;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    aes128_xts_sector_crypt DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_low(data_low), .data_high(data_high), .last_block(last_block),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_low(result_low), .result_high(result_high), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [63:0]  k1_lo, k1_hi, k2_lo, k2_hi, first_sector, sector_now;
    logic         enc_mode;
    logic [127:0] tweak;
    int           blk_idx;
    bit           new_run;

    block_t pending_blocks[$];
    block_t expected_results[$];
    int     errors;
    int     cycles;
    bit     feed_done;
    bit     hold_off;
    int     hold_left;

    logic [7:0] sb[256];
    logic [7:0] isb[256];

    function automatic logic [7:0] dbl8(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] mul8(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r ^= a;
            a = dbl8(a);
        end
        return r;
    endfunction

    // byte i of the block sits in bits 8i+7:8i
    function automatic logic [127:0] aes_block(logic [127:0] key, logic [127:0] din,
                                               bit fwd);
        logic [7:0] rk[176];
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] tmp[4];
        logic [7:0] x, rc, a0, a1, a2, a3;
        logic [127:0] dout;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[8*i +: 8];
            s[i] = din[8*i +: 8];
        end
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                tmp[j] = rk[i-4+j];
            if ((i % 16) == 0)
            begin
                x = tmp[0];
                tmp[0] = sb[tmp[1]] ^ rc;
                tmp[1] = sb[tmp[2]];
                tmp[2] = sb[tmp[3]];
                tmp[3] = sb[x];
                rc = dbl8(rc);
            end
            for (int j = 0; j < 4; j++)
                rk[i+j] = rk[i-16+j] ^ tmp[j];
        end
        if (fwd)
        begin
            for (int i = 0; i < 16; i++)
                s[i] ^= rk[i];
            for (int r = 1; r <= 10; r++)
            begin
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++)
                        t[i+4*c] = sb[s[i+4*((c+i)%4)]];
                if (r < 10)
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        t[4*c]   = dbl8(a0) ^ dbl8(a1) ^ a1 ^ a2 ^ a3;
                        t[4*c+1] = a0 ^ dbl8(a1) ^ dbl8(a2) ^ a2 ^ a3;
                        t[4*c+2] = a0 ^ a1 ^ dbl8(a2) ^ dbl8(a3) ^ a3;
                        t[4*c+3] = dbl8(a0) ^ a0 ^ a1 ^ a2 ^ dbl8(a3);
                    end
                for (int i = 0; i < 16; i++)
                    s[i] = t[i] ^ rk[16*r+i];
            end
        end
        else
        begin
            for (int i = 0; i < 16; i++)
                s[i] ^= rk[160+i];
            for (int r = 9; r >= 0; r--)
            begin
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++)
                        t[i+4*((c+i)%4)] = isb[s[i+4*c]];
                for (int i = 0; i < 16; i++)
                    s[i] = t[i] ^ rk[16*r+i];
                if (r > 0)
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        s[4*c]   = mul8(a0,14) ^ mul8(a1,11) ^ mul8(a2,13) ^ mul8(a3,9);
                        s[4*c+1] = mul8(a0,9) ^ mul8(a1,14) ^ mul8(a2,11) ^ mul8(a3,13);
                        s[4*c+2] = mul8(a0,13) ^ mul8(a1,9) ^ mul8(a2,14) ^ mul8(a3,11);
                        s[4*c+3] = mul8(a0,11) ^ mul8(a1,13) ^ mul8(a2,9) ^ mul8(a3,14);
                    end
            end
        end
        for (int i = 0; i < 16; i++)
            dout[8*i +: 8] = s[i];
        return dout;
    endfunction

    task automatic predict_sector_block(block_t b);
        logic [127:0] seed, res;
        block_t e;
        if (new_run)
        begin
            sector_now = first_sector;
            blk_idx = 0;
            new_run = 0;
        end
        if (blk_idx == 0)
        begin
            seed = '0;
            for (int i = 0; i < 8; i++)
                seed[64 + 8*i +: 8] = sector_now[8*(7-i) +: 8];
            tweak = aes_block({k2_hi, k2_lo}, seed, 1'b1);
        end
        res = aes_block({k1_hi, k1_lo}, {b.hi, b.lo} ^ tweak, enc_mode) ^ tweak;
        e.lo = res[63:0];
        e.hi = res[127:64];
        e.lst = b.lst;
        expected_results.push_back(e);
        tweak = {tweak[126:0], 1'b0} ^ (tweak[127] ? 128'h87 : 128'h0);
        blk_idx++;
        if (blk_idx >= SECTOR_BLOCKS)
        begin
            blk_idx = 0;
            sector_now++;
        end
        if (b.lst)
        begin
            blk_idx = 0;
            sector_now = first_sector;
            new_run = 1;
        end
    endtask

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // driver: bursts and gaps
    int burst_left, gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            data_low <= 0;
            data_high <= 0;
            last_block <= 0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_sector_block(pending_blocks.pop_front());
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 0;
                end
                else if (pending_blocks.size() > 0)
                begin
                    in_valid <= 1;
                    data_low <= pending_blocks[0].lo;
                    data_high <= pending_blocks[0].hi;
                    last_block <= pending_blocks[0].lst;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        if ($urandom_range(0, 2) == 0)
                            gap_left = $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor and receiver stall pattern
    logic [4:0] stall_pat;
    always @(posedge clk or negedge rst_n)
    begin
        block_t e;
        if (!rst_n)
        begin
            out_ready <= 0;
            stall_pat = 5'b10110;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected item result_low=%h", result_low);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (result_low !== e.lo)
                    begin
                        $error("result_low expected %h actual %h", e.lo, result_low);
                        errors++;
                    end
                    if (result_high !== e.hi)
                    begin
                        $error("result_high expected %h actual %h", e.hi, result_high);
                        errors++;
                    end
                    if (last !== e.lst)
                    begin
                        $error("last expected %b actual %b", e.lst, last);
                        errors++;
                    end
                end
            end
            stall_pat = {stall_pat[3:0], stall_pat[4] ^ stall_pat[2]};
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else if (hold_off)
            begin
                hold_off = 0;
                hold_left = 200;
                out_ready <= 0;
            end
            else if (cycles % 600 < 300)
                out_ready <= 1;
            else
                out_ready <= stall_pat[0] | ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("aes128_xts_sector_crypt verification failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            REG_KEY1_LOW:     k1_lo = val;
            REG_KEY1_HIGH:    k1_hi = val;
            REG_KEY2_LOW:     k2_lo = val;
            REG_KEY2_HIGH:    k2_hi = val;
            REG_START_SECTOR: first_sector = val;
            REG_ENCRYPT_MODE: enc_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic add_block(logic [63:0] lo, logic [63:0] hi, logic lst);
        block_t b;
        b.lo = lo;
        b.hi = hi;
        b.lst = lst;
        pending_blocks.push_back(b);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_idle();
        while (pending_blocks.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic add_random_runs(int count);
        int n;
        while (count > 0)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 34);
            for (int i = 0; i < n && count > 0; i++)
            begin
                add_block(rand64(), rand64(), (i == n - 1) || ($urandom_range(0, 99) == 0));
                count--;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            sb[i] = SBOX[i];
            isb[i] = INV_SBOX[i];
        end
        errors = 0;
        cycles = 0;
        hold_off = 0;
        hold_left = 0;
        k1_lo = 0; k1_hi = 0; k2_lo = 0; k2_hi = 0;
        first_sector = 0;
        enc_mode = 1;
        tweak = 0;
        blk_idx = 0;
        new_run = 1;
        cfg_valid = 0;
        cfg_index = REG_KEY1_LOW;
        cfg_data = 0;
        rst_n = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1;

        // directed: reset keys, field extremes, early last
        add_block(64'h0, 64'h0, 0);
        add_block('1, '1, 0);
        add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1);
        for (int i = 0; i < 20; i++)
            add_block(rand64(), rand64(), i == 19);
        wait_idle();

        // maximal sector wraps around, decrypt mode, all-ones keys
        write_reg(REG_KEY1_LOW, '1);
        write_reg(REG_KEY1_HIGH, '1);
        write_reg(REG_KEY2_LOW, '1);
        write_reg(REG_KEY2_HIGH, '1);
        write_reg(REG_START_SECTOR, '1);
        write_reg(REG_ENCRYPT_MODE, 64'h0);
        for (int i = 0; i < 40; i++)
            add_block(rand64(), rand64(), i == 39);
        hold_off = 1;
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_KEY1_LOW, rand64());
            write_reg(REG_KEY1_HIGH, rand64());
            write_reg(REG_KEY2_LOW, rand64());
            write_reg(REG_KEY2_HIGH, rand64());
            write_reg(REG_START_SECTOR, (phase == 2) ? 64'h0 : rand64());
            write_reg(REG_ENCRYPT_MODE, {63'h0, phase[0]});
            add_random_runs(180);
            if (phase == 1)
                hold_off = 1;
            wait_idle();
        end

        if (errors == 0)
            $display("aes128_xts_sector_crypt verification clean");
        else
            $display("aes128_xts_sector_crypt verification failed");
        $finish;
    end

endmodule
